// ----- src/spritz_sponge_cipher_core_macros.svh -----
// Assertion macros used by the sponge sequencer.
`ifndef SPRITZ_SPONGE_CIPHER_CORE_MACROS_SVH
`define SPRITZ_SPONGE_CIPHER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SSC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SSC_ASSERT(label, clk, rst_n, prop, msg)
`define SSC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- src/spritz_pkg.sv -----
package spritz_pkg;
	localparam int unsigned PermSize = 256;
	localparam int unsigned HalfSize = PermSize / 2;
	localparam int unsigned WhipLen  = PermSize * 2;
	localparam logic [3:0]  NibMask  = 4'hf;
	localparam logic [7:0]  ByteMask = 8'hff;

	typedef enum logic [1:0] {
		OP_REINIT = 2'd0,
		OP_ABSORB = 2'd1,
		OP_STOP   = 2'd2,
		OP_DRIP   = 2'd3
	} op_t;

	// Memory port request from the sequencer to the permutation store.
	typedef struct packed {
		logic       we;
		logic [7:0] addr;
		logic [7:0] wdata;
	} mem_req_t;
endpackage

// ----- src/spritz_stream_if.sv -----
interface spritz_stream_if #(parameter int unsigned Width = 8);
	logic             valid;
	logic             ready;
	logic [Width-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/spritz_in_if.sv -----
interface spritz_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

// ----- src/spritz_perm_mem.sv -----
module spritz_perm_mem (
	input  logic                 clk,
	input  spritz_pkg::mem_req_t req,
	output logic [7:0]           rdata
);
	import spritz_pkg::*;

	logic [7:0] mem [PermSize];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata <= mem[req.addr];
	end
endmodule

// ----- src/spritz_seq.sv -----
`include "spritz_sponge_cipher_core_macros.svh"
module spritz_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	spritz_in_if.sink            in_ch,
	spritz_stream_if.source      out_ch,
	output spritz_pkg::mem_req_t req,
	input  logic [7:0]           rdata
);
	import spritz_pkg::*;

	// Each memory read is issued in one state and its data used in the next.
	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISPATCH,
		S_NIB, S_NIB_RA, S_NIB_RB, S_NIB_WA,
		S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6,
		S_CR0, S_CR1, S_CR2, S_CR3,
		S_Z0, S_Z1, S_Z2, S_Z3, S_OUT
	} state_t;

	state_t     state_q;
	logic [7:0] i_q, j_q, k_q, z_q, a_q, w_q;
	logic [7:0] cnt_q;      // init sweep and crush index
	logic [8:0] upd_q;      // updates left in the current whip
	logic [2:0] phase_q;    // shuffle phase: whip, crush, whip, crush, whip
	logic       in_shuf_q;  // update belongs to a whip
	logic [1:0] op_q;
	logic [7:0] d_q;
	logic       nib_q;      // second nibble in progress
	logic [7:0] t_q, u_q;
	logic [7:0] out_q;
	logic       out_vld_q;
	logic [7:0] na;

	assign na = HalfSize[7:0] + (nib_q ? {4'd0, d_q[7:4]} : {4'd0, d_q[3:0] & NibMask});
	assign in_ch.ready = (state_q == S_IDLE) && !out_vld_q;
	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;

	always_comb begin
		req = '{we: 1'b0, addr: 8'd0, wdata: 8'd0};
		case (state_q)
			S_INIT:   req = '{we: 1'b1, addr: cnt_q, wdata: cnt_q};
			S_NIB:    req.addr = a_q;
			S_NIB_RA: req.addr = na;
			S_NIB_RB: req = '{we: 1'b1, addr: a_q, wdata: rdata};
			S_NIB_WA: req = '{we: 1'b1, addr: na, wdata: t_q};
			S_U0:     req.addr = i_q + w_q;
			S_U1:     req.addr = j_q + rdata;
			S_U2:     req.addr = k_q + rdata;
			S_U3:     req.addr = i_q;
			S_U4:     req.addr = j_q;
			S_U5:     req = '{we: 1'b1, addr: i_q, wdata: rdata};
			S_U6:     req = '{we: 1'b1, addr: j_q, wdata: t_q};
			S_CR0:    req.addr = cnt_q;
			S_CR1:    req.addr = ByteMask - cnt_q;
			S_CR2:    req = '{we: t_q > rdata, addr: cnt_q, wdata: rdata};
			S_CR3:    req = '{we: 1'b1, addr: ByteMask - cnt_q, wdata: t_q};
			S_Z0:     req.addr = z_q + k_q;
			S_Z1:     req.addr = i_q + rdata;
			S_Z2:     req.addr = j_q + rdata;
			default:  ;
		endcase
	end

	// Entry point of a shuffle phase; the last phase returns to the caller.
	function automatic state_t after_phase(input logic [2:0] ph, input logic [1:0] op);
		state_t s;
		begin
			s = S_U0;
			if (ph inside {3'd1, 3'd3}) s = S_CR0;
			else if (ph == 3'd5) s = (op == OP_DRIP) ? S_U0 : S_NIB;
			return s;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			{i_q, j_q, k_q, z_q, a_q} <= '0;
			w_q <= 8'd1;
			cnt_q <= '0;
			upd_q <= '0;
			phase_q <= '0;
			in_shuf_q <= 1'b0;
			op_q <= OP_REINIT;
			d_q <= '0;
			nib_q <= 1'b0;
			t_q <= '0;
			u_q <= '0;
			out_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_vld_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == ByteMask) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						op_q <= in_ch.opcode;
						d_q <= in_ch.data_byte;
						nib_q <= 1'b0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					in_shuf_q <= 1'b0;
					case (op_q)
						OP_REINIT: begin
							{i_q, j_q, k_q, z_q, a_q} <= '0;
							w_q <= 8'd1;
							cnt_q <= '0;
							state_q <= S_INIT;
						end
						OP_STOP: begin
							if (a_q == HalfSize[7:0]) begin
								in_shuf_q <= 1'b1;
								phase_q <= '0;
								upd_q <= WhipLen[8:0] - 9'd1;
								state_q <= S_U0;
							end else begin
								a_q <= a_q + 8'd1;
								state_q <= S_IDLE;
							end
						end
						default: begin
							if ((op_q == OP_DRIP) ? (a_q != 8'd0) : (a_q == HalfSize[7:0]))
									begin
								in_shuf_q <= 1'b1;
								phase_q <= '0;
								upd_q <= WhipLen[8:0] - 9'd1;
								state_q <= S_U0;
							end else begin
								state_q <= (op_q == OP_DRIP) ? S_U0 : S_NIB;
							end
						end
					endcase
				end
				S_NIB: state_q <= S_NIB_RA;
				S_NIB_RA: begin
					t_q <= rdata;
					state_q <= S_NIB_RB;
				end
				S_NIB_RB: state_q <= S_NIB_WA;
				S_NIB_WA: begin
					a_q <= a_q + 8'd1;
					if (nib_q) begin
						state_q <= S_IDLE;
					end else begin
						nib_q <= 1'b1;
						state_q <= S_DISPATCH;
					end
				end
				S_U0: begin
					i_q <= i_q + w_q;
					state_q <= S_U1;
				end
				S_U1: state_q <= S_U2;
				S_U2: begin
					j_q <= k_q + rdata;
					state_q <= S_U3;
				end
				S_U3: begin
					u_q <= rdata;
					state_q <= S_U4;
				end
				S_U4: begin
					k_q <= i_q + k_q + u_q;
					t_q <= rdata;
					state_q <= S_U5;
				end
				S_U5: state_q <= S_U6;
				S_U6: begin
					if (!in_shuf_q) begin
						state_q <= S_Z0;
					end else if (upd_q != 9'd0) begin
						upd_q <= upd_q - 9'd1;
						state_q <= S_U0;
					end else begin
						w_q <= w_q + 8'd2;
						phase_q <= phase_q + 3'd1;
						cnt_q <= '0;
						upd_q <= WhipLen[8:0] - 9'd1;
						if (phase_q == 3'd4) begin
							in_shuf_q <= 1'b0;
							a_q <= (op_q == OP_STOP) ? 8'd1 : 8'd0;
							state_q <= (op_q == OP_STOP) ? S_IDLE
								: after_phase(3'd5, op_q);
						end else begin
							state_q <= after_phase(phase_q + 3'd1, op_q);
						end
					end
				end
				S_CR0: state_q <= S_CR1;
				S_CR1: begin
					t_q <= rdata;
					state_q <= S_CR2;
				end
				S_CR2: state_q <= (t_q > rdata) ? S_CR3 : S_CR0;
				S_Z0: state_q <= S_Z1;
				S_Z1: state_q <= S_Z2;
				S_Z2: state_q <= S_Z3;
				S_Z3: begin
					z_q <= rdata;
					out_q <= rdata ^ d_q;
					out_vld_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// Crush loop advance and exit, shared by both branches of the compare.
			if ((state_q == S_CR2 && !(t_q > rdata)) || state_q == S_CR3) begin
				cnt_q <= cnt_q + 8'd1;
				if (cnt_q == HalfSize[7:0] - 8'd1) begin
					phase_q <= phase_q + 3'd1;
					state_q <= S_U0;
				end else begin
					state_q <= S_CR0;
				end
			end
		end
	end

	`SSC_ASSERT(a_bound, clk, arst_n, (state_q == S_IDLE) |-> (a_q <= HalfSize[7:0]), "absorb count out of range")
	`SSC_ASSERT(a_ready_idle, clk, arst_n, in_ch.ready |-> (state_q == S_IDLE), "ready outside idle")
	`SSC_ASSERT(a_out_from_z, clk, arst_n, $rose(out_vld_q) |-> $past(state_q == S_Z3), "result without keystream step")
	`SSC_ASSERT(a_phase, clk, arst_n, in_shuf_q |-> (phase_q <= 3'd4), "shuffle phase overrun")
endmodule

// ----- src/spritz_sponge_cipher_core.sv -----
// Spritz sponge (N = 256) with a single-port 256-byte permutation memory driven
// by one sequencer. After reset, and after a reinit command, the permutation is
// rebuilt by a sweep during which no command is accepted. No command is accepted
// either while a drip result waits to be taken. Any command that triggers a shuffle
// adds three whips of 512 updates and two crushes of 128 steps, the whip updates
// being bound by the serial memory reads, one per cycle.
module spritz_sponge_cipher_core (
	input  logic            clk,
	input  logic            arst_n,
	spritz_in_if.sink       in_ch,
	spritz_stream_if.source out_ch
);
	import spritz_pkg::*;

	mem_req_t   req;
	logic [7:0] rdata;

	spritz_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.req    (req),
		.rdata  (rdata)
	);

	spritz_perm_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);
endmodule

// ----- test/tb_spritz_sponge_cipher_core.sv -----
module tb_spritz_sponge_cipher_core;
	import spritz_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	spritz_in_if     in_ch ();
	spritz_stream_if out_ch ();

	spritz_sponge_cipher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Sponge state kept by the testbench.
	logic [7:0] sponge_perm [PermSize];
	logic [7:0] sponge_i, sponge_j, sponge_k, sponge_z, sponge_a, sponge_w;

	logic [7:0] keystream_q [$];
	int         mismatch_count = 0;
	int         random_items = 0;
	bit         no_idle = 0;
	int         hold_off_cycles = 0;

	always #5 clk = ~clk;

	function automatic void sponge_swap(logic [7:0] p, logic [7:0] q);
		logic [7:0] t;
		t = sponge_perm[p];
		sponge_perm[p] = sponge_perm[q];
		sponge_perm[q] = t;
	endfunction

	function automatic void sponge_reinit();
		for (int n = 0; n < PermSize; n++) sponge_perm[n] = 8'(n);
		sponge_i = 8'd0;
		sponge_j = 8'd0;
		sponge_k = 8'd0;
		sponge_z = 8'd0;
		sponge_a = 8'd0;
		sponge_w = 8'd1;
	endfunction

	function automatic void sponge_update();
		logic [7:0] t;
		sponge_i = sponge_i + sponge_w;
		t = sponge_j + sponge_perm[sponge_i];
		sponge_j = sponge_k + sponge_perm[t];
		sponge_k = sponge_i + sponge_k + sponge_perm[sponge_j];
		sponge_swap(sponge_i, sponge_j);
	endfunction

	function automatic void sponge_whip();
		for (int c = 0; c < WhipLen; c++) sponge_update();
		sponge_w = sponge_w + 8'd2;
	endfunction

	function automatic void sponge_crush();
		for (int v = 0; v < HalfSize; v++) begin
			if (sponge_perm[v] > sponge_perm[PermSize - 1 - v])
				sponge_swap(8'(v), 8'(PermSize - 1 - v));
		end
	endfunction

	function automatic void sponge_shuffle();
		sponge_whip();
		sponge_crush();
		sponge_whip();
		sponge_crush();
		sponge_whip();
		sponge_a = 8'd0;
	endfunction

	function automatic void sponge_nibble(logic [3:0] nib);
		if (sponge_a == HalfSize) sponge_shuffle();
		sponge_swap(sponge_a, 8'(HalfSize) + {4'd0, nib});
		sponge_a = sponge_a + 8'd1;
	endfunction

	// Applies one accepted command and queues the keystream result of a drip.
	function automatic void sponge_command(op_t op, logic [7:0] d);
		logic [7:0] t;
		case (op)
			OP_REINIT: sponge_reinit();
			OP_ABSORB: begin
				sponge_nibble(d[3:0]);
				sponge_nibble(d[7:4]);
			end
			OP_STOP: begin
				if (sponge_a == HalfSize) sponge_shuffle();
				sponge_a = sponge_a + 8'd1;
			end
			default: begin
				if (sponge_a > 0) sponge_shuffle();
				sponge_update();
				t = sponge_z + sponge_k;
				t = sponge_i + sponge_perm[t];
				t = sponge_j + sponge_perm[t];
				sponge_z = sponge_perm[t];
				keystream_q.push_back(sponge_z ^ d);
			end
		endcase
	endfunction

	task automatic report(string what, logic [7:0] got, logic [7:0] want);
		$display("ERROR at %0t: %s got %02h expected %02h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_cmd(op_t op, logic [7:0] d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.data_byte <= d;
		do @(posedge clk); while (!in_ch.ready);
		sponge_command(op, d);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (keystream_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: a random stall before each transaction, or a long hold on request.
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 9);
				if (stall > 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid && hold_off_cycles == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (keystream_q.size() == 0)
				report("unexpected keystream byte", out_ch.data, 8'h00);
			else if (out_ch.data !== keystream_q[0]) begin
				report("keystream byte", out_ch.data, keystream_q[0]);
				void'(keystream_q.pop_front());
			end else
				void'(keystream_q.pop_front());
		end
	end

	task automatic test_directed();
		send_cmd(OP_DRIP, 8'h00);
		send_cmd(OP_DRIP, 8'hff);
		send_cmd(OP_ABSORB, 8'h00);
		send_cmd(OP_ABSORB, 8'hff);
		send_cmd(OP_STOP, 8'h00);
		send_cmd(OP_DRIP, 8'h00);
		send_cmd(OP_DRIP, 8'h5a);
		send_cmd(OP_REINIT, 8'hff);
		send_cmd(OP_STOP, 8'hff);
		send_cmd(OP_DRIP, 8'ha5);
		send_cmd(OP_REINIT, 8'h00);
		send_cmd(OP_DRIP, 8'h01);
		send_cmd(OP_DRIP, 8'h80);
	endtask

	// A well-formed message: optional reinit, absorb, optional stop, then a run of drips.
	// Now and then the absorb runs up to the half-full counter so that the
	// in-line shuffle on absorb or stop is reached.
	task automatic random_sequence();
		int n_abs, n_drip, kind;
		kind = $urandom_range(0, 15);
		if ($urandom_range(0, 3) != 0) begin
			send_cmd(OP_REINIT, 8'($urandom));
			random_items++;
		end
		n_abs = (kind == 0) ? $urandom_range(63, 65) : $urandom_range(0, 6);
		for (int n = 0; n < n_abs; n++) begin
			if (kind == 0 && n == 64 && $urandom_range(0, 1)) send_cmd(OP_STOP, 8'($urandom));
			else send_cmd(OP_ABSORB, 8'($urandom));
			random_items++;
		end
		if ($urandom_range(0, 1)) begin
			send_cmd(OP_STOP, 8'($urandom));
			random_items++;
		end
		n_drip = $urandom_range(8, 25);
		for (int n = 0; n < n_drip; n++) begin
			// Occasional noise: a stray absorb or stop inside the drip run.
			if ($urandom_range(0, 40) == 0)
				send_cmd(op_t'($urandom_range(1, 2)), 8'($urandom));
			else
				send_cmd(OP_DRIP, ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
			random_items++;
		end
	endtask

	task automatic test_random();
		while (random_items < 1180) begin
			no_idle = ($urandom_range(0, 5) == 0);
			random_sequence();
		end
		no_idle = 0;
	endtask

	task automatic test_backpressure();
		send_cmd(OP_REINIT, 8'h00);
		hold_off_cycles = 400;
		for (int n = 0; n < 40; n++) send_cmd(OP_DRIP, 8'($urandom));
	endtask

	task automatic test_drain_pause();
		wait_drained();
		send_cmd(OP_ABSORB, 8'($urandom));
		send_cmd(OP_DRIP, 8'($urandom));
		send_cmd(OP_DRIP, 8'($urandom));
	endtask

	initial begin
		int guard;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.opcode    = OP_REINIT;
		in_ch.data_byte = 8'h00;
		sponge_reinit();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_drain_pause();
		test_random();
		test_drain_pause();
		in_ch.valid <= 1'b0;
		guard = 0;
		while (keystream_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		// A trailing absorb may still be shuffling; allow for one full shuffle.
		repeat (13000) @(posedge clk);
		if (mismatch_count == 0 && keystream_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#150000000;
		$display("Mismatches found");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+src
src/spritz_pkg.sv
src/spritz_stream_if.sv
src/spritz_in_if.sv
src/spritz_perm_mem.sv
src/spritz_seq.sv
src/spritz_sponge_cipher_core.sv
test/tb_spritz_sponge_cipher_core.sv
